// ----- rtl/can_frame_to_slcan_ascii_assert.svh -----
`ifndef CAN_FRAME_TO_SLCAN_ASCII_ASSERT_SVH
`define CAN_FRAME_TO_SLCAN_ASCII_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CFSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slcan encoder: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slcan encoder: next-cycle check failed");

`endif

// ----- rtl/slcan_pkg.sv -----
package slcan_pkg;

    localparam int FrameW  = 116;
    localparam int TdataW  = 120;
    localparam int StreamW = 116;
    localparam int CountW  = 5;
    localparam int DataW   = 64;
    localparam int StampW  = 16;
    localparam int TailW   = DataW + StampW;

    localparam logic [7:0] AsciiCr  = 8'h0D;
    localparam logic [7:0] AsciiExt = 8'h54;
    localparam logic [7:0] AsciiStd = 8'h74;

    typedef struct packed {
        logic                ext;
        logic [StreamW-1:0]  stream;
        logic [CountW-1:0]   count;
    } t_desc;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
        end else begin
            ch = 8'h37 + {4'd0, nib};
        end
        return ch;
    endfunction

endpackage

// ----- rtl/can_frame_to_slcan_ascii.sv -----
// Turns each received CAN frame into its slcan text line and sends it out one
// ASCII character per beat, ending with a carriage return that carries tlast.
// The output runs at one character per clock while tready stays high, and a
// line holds between 6 and 31 characters: one type letter, three or eight id
// digits, one length digit, two digits per printed data byte, four timestamp
// digits when enabled, and the carriage return. Lines of queued frames follow
// each other without idle cycles. Frames are taken into a two-entry queue, so
// the input keeps accepting while a line is sent, until the queue is full.
// The timestamp enable should only be changed while no line is pending.
`include "can_frame_to_slcan_ascii_assert.svh"

module can_frame_to_slcan_ascii (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // raw_id[31:0], length_code[35:32], byte_0..byte_7[99:36], stamp_ms[115:100].
    input  logic [slcan_pkg::TdataW-1:0] i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // ascii_char[7:0].
    output logic [7:0]                   o_m_axis_tdata,
    output logic                         o_m_axis_tlast
);

    logic             r_ts_en;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    slcan_pkg::t_desc desc;
    slcan_pkg::t_desc head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_ts_en <= i_cfg_wdata;
        end
    end

    slcan_front u_front (
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_ts_en (r_ts_en),
        .i_full  (full),
        .o_push  (push),
        .o_desc  (desc)
    );

    slcan_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    slcan_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_char  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

    `CFSA_ASSERT_SAME(a_last_is_cr, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tdata == slcan_pkg::AsciiCr)
    `CFSA_ASSERT_SAME(a_cr_only_last, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, o_m_axis_tdata != slcan_pkg::AsciiCr)
    `CFSA_ASSERT_NEXT(a_line_starts, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, !o_m_axis_tvalid || o_m_axis_tdata == slcan_pkg::AsciiExt || o_m_axis_tdata == slcan_pkg::AsciiStd)

endmodule

// ----- rtl/slcan_front.sv -----
module slcan_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [slcan_pkg::TdataW-1:0] i_data,
    input  logic                        i_ts_en,
    input  logic                        i_full,
    output logic                        o_push,
    output slcan_pkg::t_desc            o_desc
);

    logic [31:0]                   raw_id;
    logic [3:0]                    len;
    logic [slcan_pkg::StampW-1:0]  stamp;
    logic [slcan_pkg::StampW-1:0]  stamp_g;
    logic [3:0]                    nbytes;
    logic [6:0]                    shift;
    logic [slcan_pkg::DataW-1:0]   data_msb;
    logic [slcan_pkg::DataW-1:0]   keep_mask;
    logic [slcan_pkg::TailW-1:0]   tail;
    logic [slcan_pkg::CountW-1:0]  id_digits;
    logic [slcan_pkg::CountW-1:0]  ts_digits;

    always_comb begin
        raw_id  = i_data[31:0];
        len     = i_data[35:32];
        stamp   = i_data[115:100];
        stamp_g = i_ts_en ? stamp : '0;
        nbytes  = len[3] ? 4'd8 : len;
        shift   = {nbytes, 3'b000};
        for (int k = 0; k < 8; k++) begin
            data_msb[slcan_pkg::DataW-1-8*k -: 8] = i_data[36+8*k +: 8];
        end
        keep_mask = ~({slcan_pkg::DataW{1'b1}} >> shift);
        tail = {data_msb & keep_mask, {slcan_pkg::StampW{1'b0}}}
             | ({stamp_g, {slcan_pkg::DataW{1'b0}}} >> shift);
        id_digits = raw_id[31] ? 5'd8 : 5'd3;
        ts_digits = i_ts_en ? 5'd4 : 5'd0;

        o_desc.ext   = raw_id[31];
        o_desc.count = id_digits + 5'd1 + {nbytes, 1'b0} + ts_digits;
        if (raw_id[31]) begin
            o_desc.stream = {3'b000, raw_id[28:0], len, tail};
        end else begin
            o_desc.stream = {raw_id[11:0], len, tail, 20'd0};
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// ----- rtl/slcan_fifo.sv -----
module slcan_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  slcan_pkg::t_desc i_desc,
    input  logic             i_pop,
    output slcan_pkg::t_desc o_head,
    output logic             o_full,
    output logic             o_empty
);

    slcan_pkg::t_desc r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/slcan_back.sv -----
module slcan_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slcan_pkg::t_desc i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_char,
    output logic             o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIGITS,
        S_END
    } t_state;

    t_state                          r_state;
    logic                            r_valid;
    logic [7:0]                      r_char;
    logic                            r_last;
    logic [slcan_pkg::StreamW-1:0]   r_stream;
    logic [slcan_pkg::CountW-1:0]    r_left;
    logic                            adv;

    assign adv   = !r_valid || i_ready;
    assign o_pop = adv && (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else if (adv) begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_valid  <= 1'b1;
                        r_char   <= i_head.ext ? slcan_pkg::AsciiExt : slcan_pkg::AsciiStd;
                        r_last   <= 1'b0;
                        r_stream <= i_head.stream;
                        r_left   <= i_head.count;
                        r_state  <= S_DIGITS;
                    end else begin
                        r_valid <= 1'b0;
                    end
                end
                S_DIGITS: begin
                    r_valid  <= 1'b1;
                    r_char   <= slcan_pkg::hex_char(
                        r_stream[slcan_pkg::StreamW-1 -: 4]);
                    r_last   <= 1'b0;
                    r_stream <= r_stream << 4;
                    r_left   <= r_left - 5'd1;
                    if (r_left == 5'd1) begin
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    r_valid <= 1'b1;
                    r_char  <= slcan_pkg::AsciiCr;
                    r_last  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

// ----- tb/tb_can_frame_to_slcan_ascii.sv -----
`timescale 1ns / 1ps

class slcan_line_checker;
    bit          ts_on;
    logic [8:0]  line_chars[$];
    int          failures;

    function void report(string what, logic [8:0] want, logic [8:0] got);
        failures++;
        if (failures <= 10) begin
            $display("%0t: %s: expected char %h last %b, got char %h last %b",
                     $time, what, want[7:0], want[8], got[7:0], got[8]);
        end
    endfunction

    function logic [7:0] hex_ascii(logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + nib : 8'h41 + nib - 8'd10;
    endfunction

    function void push_char(logic [7:0] ch);
        line_chars.push_back({1'b0, ch});
    endfunction

    function void note_frame(logic [slcan_pkg::TdataW-1:0] beat);
        logic [31:0] raw_id;
        logic [31:0] id;
        logic [3:0]  len;
        logic [15:0] stamp;
        logic [7:0]  data_byte;
        int          nbytes;
        int          i;
        raw_id = beat[31:0];
        len    = beat[35:32];
        stamp  = beat[115:100];
        id     = raw_id & 32'h1FFF_FFFF;
        if (raw_id[31]) begin
            push_char(slcan_pkg::AsciiExt);
            for (i = 7; i >= 0; i--) begin
                push_char(hex_ascii(id[4*i +: 4]));
            end
        end else begin
            push_char(slcan_pkg::AsciiStd);
            push_char(hex_ascii(id[11:8]));
            push_char(hex_ascii(id[7:4]));
            push_char(hex_ascii(id[3:0]));
        end
        push_char(hex_ascii(len));
        nbytes = (len > 4'd8) ? 8 : len;
        for (i = 0; i < nbytes; i++) begin
            data_byte = beat[36 + 8*i +: 8];
            push_char(hex_ascii(data_byte[7:4]));
            push_char(hex_ascii(data_byte[3:0]));
        end
        if (ts_on) begin
            push_char(hex_ascii(stamp[15:12]));
            push_char(hex_ascii(stamp[11:8]));
            push_char(hex_ascii(stamp[7:4]));
            push_char(hex_ascii(stamp[3:0]));
        end
        line_chars.push_back({1'b1, slcan_pkg::AsciiCr});
    endfunction

    function void check_char(logic [7:0] ch, logic last);
        logic [8:0] want;
        if (line_chars.size() == 0) begin
            report("unexpected character", 9'h0, {last, ch});
            return;
        end
        want = line_chars.pop_front();
        if (ch !== want[7:0] || last !== want[8]) begin
            report("character mismatch", want, {last, ch});
        end
    endfunction

    function void close();
        if (line_chars.size() != 0) begin
            failures++;
            $display("%0d characters never arrived", line_chars.size());
        end
    endfunction
endclass

module tb_can_frame_to_slcan_ascii;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_wdata = 1'b0;
    logic                         i_s_axis_tvalid = 1'b0;
    logic                         o_s_axis_tready;
    logic [slcan_pkg::TdataW-1:0] i_s_axis_tdata = '0;
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready = 1'b0;
    logic [7:0]                   o_m_axis_tdata;
    logic                         o_m_axis_tlast;

    logic              full_rate = 1'b0;
    logic              hold_req = 1'b0;
    int                hold_left = 0;

    slcan_line_checker line_check = new();

    can_frame_to_slcan_ascii dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [slcan_pkg::TdataW-1:0] pack_frame(
        logic [31:0] raw_id, logic [3:0] len, logic [63:0] data, logic [15:0] stamp);
        return {{(slcan_pkg::TdataW - slcan_pkg::FrameW){1'b0}}, stamp, data, len, raw_id};
    endfunction

    function automatic logic [slcan_pkg::TdataW-1:0] random_frame();
        logic [31:0] raw_id;
        logic [3:0]  len;
        raw_id = $urandom();
        len = ($urandom_range(99) < 75) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
        return pack_frame(raw_id, len, {$urandom(), $urandom()}, 16'($urandom_range(65535)));
    endfunction

    task automatic send_frame(input logic [slcan_pkg::TdataW-1:0] beat);
        if (!full_rate && $urandom_range(99) < 37) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 37) begin
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= beat;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        line_check.note_frame(beat);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (line_check.line_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_timestamp(input logic enable);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= enable;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        line_check.ts_on = enable;
    endtask

    // Receiver: checks each accepted beat and drives tready, including one long hold-off.
    initial begin
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                line_check.check_char(o_m_axis_tdata, o_m_axis_tlast);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = 400;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= full_rate || ($urandom_range(99) >= 37);
            end
        end
    end

    initial begin
        int ph;
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_timestamp(1'b0);
        send_frame(pack_frame(32'h0000_0000, 4'd0, 64'h0, 16'h0000));
        send_frame(pack_frame(32'h0000_0FFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF));
        send_frame(pack_frame(32'h7FFF_FFFF, 4'd15, 64'hEFCD_AB89_6745_2301, 16'h1234));
        send_frame(pack_frame(32'h8000_0000, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000));
        send_frame(pack_frame(32'hFFFF_FFFF, 4'd8, 64'h0, 16'hFFFF));
        send_frame(pack_frame(32'h9FFF_FFFF, 4'd9, 64'h0123_4567_89AB_CDEF, 16'h0F0F));
        send_frame(pack_frame(32'h6000_0ABC, 4'd1, 64'hDEAD_BEEF_CAFE_F0A5, 16'h5555));
        for (n = 2; n < 8; n++) begin
            send_frame(pack_frame({n[0], 31'h1234_5678 >> n}, 4'(n),
                                  {$urandom(), $urandom()}, 16'($urandom_range(65535))));
        end
        send_frame(pack_frame(32'h0000_0800, 4'd12, 64'hEFCD_AB89_6745_2301, 16'hAAAA));

        set_timestamp(1'b1);
        send_frame(pack_frame(32'hFFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF));
        send_frame(pack_frame(32'h0000_0000, 4'd0, 64'h0, 16'h0000));
        send_frame(pack_frame(32'h0000_0123, 4'd4, 64'h0000_0000_7654_3210, 16'h89AB));
        send_frame(pack_frame(32'hA5A5_A5A5, 4'd15, 64'h1122_3344_5566_7788, 16'h5A5A));

        for (ph = 0; ph < 4; ph++) begin
            set_timestamp(ph[0]);
            full_rate <= (ph == 1);
            hold_req  <= (ph == 3);
            for (n = 0; n < 112; n++) begin
                send_frame(random_frame());
            end
        end
        full_rate <= 1'b0;

        wait_drained();
        repeat (64) @(posedge i_clk);
        line_check.close();
        if (line_check.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
